// ===== rtl/cb2cd_pkg.sv =====
// ----------------------------------------------------------------------------
// cb2cd_pkg
// shared types and constants of the alternating 2x2 block detector
// ----------------------------------------------------------------------------
package cb2cd_pkg;

    // configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 9;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GRID_COLUMNS = 1'b0,
        REG_GRID_ROWS    = 1'b1
    } cfg_index_t;

    localparam logic [CFG_DATA_W-1:0] GRID_DIM_RESET = 9'd21;
    localparam logic [CFG_DATA_W-1:0] GRID_DIM_MIN   = 9'd2;
    localparam logic [CFG_DATA_W-1:0] ROW_LIMIT      = 9'd256;

    // stream payload widths
    localparam int MODULE_W = 8;
    localparam int COORD_W  = 8;
    localparam int ROW_W    = 8;

    // result as it sits in the output register
    typedef struct packed {
        logic [COORD_W-1:0] center_x;
        logic [COORD_W-1:0] center_y;
        logic               pattern_family;
    } result_t;

endpackage

// ===== rtl/cb2cd_ram.sv =====
// ----------------------------------------------------------------------------
// cb2cd_ram
// simple dual-port ram, one write port, one read port with registered read
// ----------------------------------------------------------------------------
module cb2cd_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/checkerboard_2x2_corner_detect.sv =====
// ----------------------------------------------------------------------------
// checkerboard_2x2_corner_detect
// finds alternating 2x2 module blocks in a raster-ordered module grid
// ----------------------------------------------------------------------------
// Modules of a grid enter one per transfer on the s_ channel in raster order;
// a nonzero byte counts as a dark module. The block takes one module every
// clock cycle unless the input stalls as below. The bit row above is held in
// a line buffer ram with a registered read: the read is issued when a module
// is accepted and the window is evaluated in the next cycle, from stage 1;
// the new bit is written back at the same column when stage 1 moves on. A
// result is loaded into the output register as its module leaves stage 1.
// The input keeps flowing while a result waits to be taken, until a second
// match finds the output register still full; then the module holding that
// match and the input stall until the waiting result is taken.
// One result is sent for every window whose bits alternate: center_x/center_y
// give the window's top-left column and row plus one, pattern_family is 0 for
// [1 0; 0 1] and 1 for [0 1; 1 0]. Row 0 and column 0 never produce a result.
// After the last module of a grid both counters wrap. grid_columns is clamped
// to [2, MAX_COLUMNS] and grid_rows to [2, 256]; write them only while the
// block is idle. The line buffer has no reset and needs no clearing pass.
// ----------------------------------------------------------------------------
module checkerboard_2x2_corner_detect #(
    parameter int MAX_COLUMNS = 256
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // configuration writes
    input  logic                                cfg_we,
    input  logic [cb2cd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [cb2cd_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    // module stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [7:0]                          s_tdata,   // [7:0] module_value
    // result stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [15:0]                         m_tdata,   // [7:0] center_x, [15:8] center_y
    output logic [0:0]                          m_tuser    // [0] pattern_family
);

    import cb2cd_pkg::*;

    localparam int COL_W = $clog2(MAX_COLUMNS);
    localparam int LIM_W = $clog2(MAX_COLUMNS + 1);
    localparam int EXT_W = (LIM_W > CFG_DATA_W) ? LIM_W : CFG_DATA_W;

    // configuration registers
    logic [CFG_DATA_W-1:0] grid_columns_reg;
    logic [CFG_DATA_W-1:0] grid_rows_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grid_columns_reg <= GRID_DIM_RESET;
            grid_rows_reg    <= GRID_DIM_RESET;
        end else if (cfg_we) begin
            case (cfg_index_t'(cfg_index))
                REG_GRID_COLUMNS: grid_columns_reg <= cfg_wdata;
                REG_GRID_ROWS:    grid_rows_reg    <= cfg_wdata;
                default:          ;
            endcase
        end
    end

    // clamped grid size
    logic [EXT_W-1:0]      cols_ext;
    logic [EXT_W-1:0]      cols_eff;
    logic [CFG_DATA_W-1:0] rows_eff;

    always_comb begin
        cols_ext = EXT_W'(grid_columns_reg);
        if (cols_ext < EXT_W'(GRID_DIM_MIN)) begin
            cols_eff = EXT_W'(GRID_DIM_MIN);
        end else if (cols_ext > EXT_W'(MAX_COLUMNS)) begin
            cols_eff = EXT_W'(MAX_COLUMNS);
        end else begin
            cols_eff = cols_ext;
        end

        if (grid_rows_reg < GRID_DIM_MIN) begin
            rows_eff = GRID_DIM_MIN;
        end else if (grid_rows_reg > ROW_LIMIT) begin
            rows_eff = ROW_LIMIT;
        end else begin
            rows_eff = grid_rows_reg;
        end
    end

    // handshake control
    logic s_xfer;
    logic m_xfer;
    logic out_free;
    logic st1_go;
    logic st1_match;

    // raster position of the next module
    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic             col_wrap;

    assign col_wrap = (EXT_W'(col_reg) + EXT_W'(1)) >= cols_eff;

    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (s_xfer) begin
            if (col_wrap) begin
                col_next = '0;
                if ((CFG_DATA_W'(row_reg) + CFG_DATA_W'(1)) >= rows_eff) begin
                    row_next = '0;
                end else begin
                    row_next = row_reg + ROW_W'(1);
                end
            end else begin
                col_next = col_reg + COL_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // stage 1: module waiting for its line buffer read
    logic             st1_valid_reg, st1_valid_next;
    logic             st1_bit_reg;
    logic [COL_W-1:0] st1_col_reg;
    logic [ROW_W-1:0] st1_row_reg;

    always_comb begin
        st1_valid_next = st1_valid_reg;
        if (s_xfer) begin
            st1_valid_next = 1'b1;
        end else if (st1_go) begin
            st1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st1_valid_reg <= 1'b0;
        end else begin
            st1_valid_reg <= st1_valid_next;
        end
    end

    // payload of stage 1, no reset
    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            st1_bit_reg <= (s_tdata != '0);
            st1_col_reg <= col_reg;
            st1_row_reg <= row_reg;
        end
    end

    // line buffer: read at accept, written back when stage 1 moves on.
    // consecutive modules always sit in different columns, and a column is
    // read again only after its previous write has landed, so no forwarding
    logic             ram_we;
    logic             ram_re;
    logic [COL_W-1:0] ram_waddr;
    logic [COL_W-1:0] ram_raddr;
    logic             above_bit;

    assign ram_we    = st1_go;
    assign ram_waddr = st1_col_reg;
    assign ram_re    = s_xfer;
    assign ram_raddr = col_reg;

    cb2cd_ram #(
        .WIDTH (1),
        .DEPTH (MAX_COLUMNS)
    ) u_line_buf (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (st1_bit_reg),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (above_bit)
    );

    // left column of the 2x2 window
    logic upper_left_reg;
    logic lower_left_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upper_left_reg <= 1'b0;
            lower_left_reg <= 1'b0;
        end else if (st1_go) begin
            upper_left_reg <= above_bit;
            lower_left_reg <= st1_bit_reg;
        end
    end

    // alternating window: diagonals equal, neighbors differ
    assign st1_match = st1_valid_reg
                    && (st1_row_reg != '0)
                    && (st1_col_reg != '0)
                    && (upper_left_reg == st1_bit_reg)
                    && (above_bit == lower_left_reg)
                    && (upper_left_reg != above_bit);

    // output register
    logic    m_valid_reg, m_valid_next;
    result_t m_result_reg;
    logic    out_load;

    assign out_free = !m_valid_reg || m_tready;
    assign st1_go   = st1_valid_reg && (!st1_match || out_free);
    assign out_load = st1_match && out_free;
    assign s_tready = !st1_valid_reg || st1_go;
    assign s_xfer   = s_tvalid && s_tready;
    assign m_xfer   = m_valid_reg && m_tready;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_xfer) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_result_reg.center_x       <= COORD_W'(st1_col_reg);
            m_result_reg.center_y       <= st1_row_reg;
            m_result_reg.pattern_family <= !upper_left_reg;
        end
    end

    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = {m_result_reg.center_y, m_result_reg.center_x};
    assign m_tuser[0] = m_result_reg.pattern_family;

    // checks

    // an accepted module always lands in stage 1
    a_accept_fills_st1: assert property (@(posedge aclk) disable iff (!aresetn)
        s_xfer |=> st1_valid_reg)
        else $error("accepted module missing from stage 1");

    // a stalled stage 1 keeps its module
    a_st1_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (st1_valid_reg && !st1_go) |=> (st1_valid_reg && $stable(st1_col_reg)
                                        && $stable(st1_bit_reg)))
        else $error("stage 1 changed while stalled");

    // line buffer read never collides with the write-back of the same column
    a_no_rw_collision: assert property (@(posedge aclk) disable iff (!aresetn)
        (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
        else $error("line buffer read and write hit the same column");

endmodule

// ===== sim/tb_checkerboard_2x2_corner_detect.sv =====
// ----------------------------------------------------------------------------
// tb_checkerboard_2x2_corner_detect
// self-checking bench for the alternating 2x2 block detector
// ----------------------------------------------------------------------------
// Module bytes are streamed in raster order while the bench tracks its own
// copy of the line buffer, the window bits and the row/column counters. Each
// accepted module may add one expected corner; every result transfer is
// compared with the oldest one. Grid sizes are swept through clamped, extreme
// and random settings, including writes in the middle of a grid, while both
// stream sides idle in bursts and stall patterns.
// ----------------------------------------------------------------------------
module tb_checkerboard_2x2_corner_detect;
    timeunit 1ns;
    timeprecision 1ps;

    import cb2cd_pkg::*;

    localparam int MAX_COLUMNS   = 256;
    localparam int ROW_MAX       = 256;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int RANDOM_ITEMS  = 120;
    localparam int LONG_HOLD     = 300;
    localparam int SETTLE_CYCLES = 8;
    localparam int MAX_REPORTS   = 10;

    // receiver stall patterns
    typedef enum logic [1:0] {
        RX_ALWAYS,
        RX_ALTERNATE,
        RX_SPARSE,
        RX_DENSE
    } rx_mode_t;

    // dut ports, all inputs driven to known values from time zero
    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata   = '0;    // [7:0] module_value
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [15:0]           m_tdata;           // [7:0] center_x, [15:8] center_y
    logic [0:0]            m_tuser;           // [0] pattern_family

    // shadow of the block: line buffer, window bits, counters, registers
    bit                    line_bits    [MAX_COLUMNS];
    bit                    line_written [MAX_COLUMNS];
    bit                    upper_left;
    bit                    lower_left;
    int                    col_idx;
    int                    row_idx;
    logic [CFG_DATA_W-1:0] grid_cols_reg;
    logic [CFG_DATA_W-1:0] grid_rows_reg;

    // corners still owed by the block, oldest first
    result_t               expected_corners[$];

    int                    failures;
    int                    reports;
    int                    cycle_count;

    // sender burst state
    int                    burst_left;
    bit                    offering;

    // receiver state
    bit                    hold_request;
    int                    hold_left;
    rx_mode_t              rx_mode;
    int                    rx_left;
    bit                    rx_phase;

    checkerboard_2x2_corner_detect #(
        .MAX_COLUMNS(MAX_COLUMNS)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // hard stop in case the block hangs
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d corners pending",
                     cycle_count, expected_corners.size());
            $display("status: fail");
            $finish;
        end
    end

    function automatic int clamp_dim(input logic [CFG_DATA_W-1:0] value, input int hi);
        if (value < 2) return 2;
        if (value > hi) return hi;
        return int'(value);
    endfunction

    // one module into the shadow window; queues a corner when the window alternates
    task automatic predict_corner(input logic [7:0] value);
        int      cols;
        int      rows;
        bit      cur;
        bit      above;
        result_t corner;
        cols  = clamp_dim(grid_cols_reg, MAX_COLUMNS);
        rows  = clamp_dim(grid_rows_reg, ROW_MAX);
        cur   = (value != 8'd0);
        above = line_bits[col_idx];
        // row 0 and column 0 never close a window
        if (row_idx > 0 && col_idx > 0 && upper_left == cur && above == lower_left &&
            upper_left != above) begin
            corner.center_x       = 8'(col_idx);
            corner.center_y       = 8'(row_idx);
            corner.pattern_family = ~upper_left;
            expected_corners.push_back(corner);
        end
        upper_left            = above;
        lower_left            = cur;
        line_bits[col_idx]    = cur;
        line_written[col_idx] = 1'b1;
        // a counter at or past a shrunken limit wraps here too
        if (col_idx + 1 >= cols) begin
            col_idx = 0;
            row_idx = (row_idx + 1 >= rows) ? 0 : row_idx + 1;
        end else begin
            col_idx = col_idx + 1;
        end
    endtask

    // register write, only issued while the block is idle
    task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        if (idx == REG_GRID_COLUMNS) begin
            grid_cols_reg = value;
        end else begin
            grid_rows_reg = value;
        end
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    // offer one module and hold it until the transfer; bursts end in a gap
    task automatic send_module(input logic [7:0] value);
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        offering  = 1'b1;
        do @(posedge aclk); while (!(s_tvalid && s_tready));
        predict_corner(value);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            s_tvalid <= 1'b0;
            offering  = 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
            // now and then a long stretch without gaps
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 250)
                                                     : $urandom_range(0, 15);
        end
    endtask

    // checkerboard content with a share of flipped modules; 50 percent is pure noise
    task automatic send_grid_run(input int count, input int flip_pct);
        bit dark;
        for (int i = 0; i < count; i++) begin
            dark = ((col_idx + row_idx) % 2 == 1) ^ ($urandom_range(0, 99) < flip_pct);
            send_module(dark ? 8'($urandom_range(1, 255)) : 8'd0);
        end
    endtask

    // stop offering, let every owed corner arrive, then let the pipeline settle
    task automatic wait_idle();
        if (offering) begin
            s_tvalid <= 1'b0;
            offering  = 1'b0;
        end
        while (expected_corners.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // ------------------------------------------------------------------------
    // test tasks
    // ------------------------------------------------------------------------

    // one full grid at the reset size, no register written yet
    task automatic test_reset_size();
        send_grid_run(21 * 21, 10);
        wait_idle();
    endtask

    // smallest grid through clamped low values, both families and plain windows
    task automatic test_directed_windows();
        write_reg(REG_GRID_COLUMNS, 9'd0);
        write_reg(REG_GRID_ROWS, 9'd1);
        // [1 0; 0 1] with extreme bytes
        send_module(8'd255); send_module(8'd0); send_module(8'd0); send_module(8'd1);
        // [0 1; 1 0], row 0 of this grid must not pair with the last grid
        send_module(8'd0); send_module(8'd128); send_module(8'd127); send_module(8'd0);
        // no alternation: horizontal stripes, then all dark
        send_module(8'd1); send_module(8'd64); send_module(8'd0); send_module(8'd0);
        send_module(8'd2); send_module(8'd4); send_module(8'd8); send_module(8'd16);
        wait_idle();
    endtask

    // width and height changed while a grid is half done; ends at row 0, column 1
    task automatic test_midgrid_writes();
        write_reg(REG_GRID_COLUMNS, 9'd3);
        send_module(8'd1); send_module(8'd0); send_module(8'd32);
        send_module(8'd0);
        wait_idle();
        // shrink the width while the column counter sits on the new last column
        write_reg(REG_GRID_COLUMNS, 9'd2);
        send_module(8'd1);
        send_module(8'd0); send_module(8'd1); send_module(8'd1);
        wait_idle();
        // grow the height mid-grid, stop on the new last row
        write_reg(REG_GRID_ROWS, 9'd3);
        send_module(8'd0); send_module(8'd0); send_module(8'd1);
        wait_idle();
        // shrink the height while the counters sit at row 0, column 0
        write_reg(REG_GRID_ROWS, 9'd2);
        send_module(8'd0);
        wait_idle();
    endtask

    // widest and tallest grids, clamped from above and below
    task automatic test_extreme_sizes();
        // the rest of row 0 fills the line buffer to its last entry, a part of row 1 follows
        write_reg(REG_GRID_COLUMNS, 9'd511);
        write_reg(REG_GRID_ROWS, 9'd0);
        send_grid_run(256 + 16, 20);
        wait_idle();
        // row counter runs through its last value and wraps
        write_reg(REG_GRID_COLUMNS, 9'd2);
        write_reg(REG_GRID_ROWS, 9'd511);
        send_grid_run(2 * 256 + 4, 5);
        wait_idle();
    endtask

    // receiver holds off long while modules keep coming, so the input stalls
    task automatic test_backpressure();
        write_reg(REG_GRID_COLUMNS, 9'd12);
        write_reg(REG_GRID_ROWS, 9'd9);
        hold_request = 1'b1;
        send_grid_run(60, 0);
        wait_idle();
    endtask

    // sender pauses mid-grid until every corner has been taken
    task automatic test_drain_pause();
        send_grid_run(20, 10);
        wait_idle();
        send_grid_run(20, 10);
        wait_idle();
    endtask

    // random sizes and contents, registers rewritten between uneven chunks
    task automatic test_random_grids();
        int                    sent;
        int                    count;
        int                    prefix;
        int                    pct;
        int                    which;
        logic [CFG_DATA_W-1:0] new_cols;
        logic [CFG_DATA_W-1:0] new_rows;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            if ($urandom_range(0, 9) == 0) begin
                new_cols = 9'($urandom_range(200, 511));
                new_rows = 9'($urandom_range(0, 3));
            end else begin
                new_cols = 9'($urandom_range(0, 30));
                new_rows = 9'($urandom_range(0, 14));
            end
            // a wider grid mid-way must not read line buffer entries never written
            prefix = 0;
            while (prefix < MAX_COLUMNS && line_written[prefix]) prefix++;
            which = $urandom_range(1, 3);
            if (which[0] && (row_idx == 0 || clamp_dim(new_cols, MAX_COLUMNS) <= prefix)) begin
                write_reg(REG_GRID_COLUMNS, new_cols);
            end
            if (which[1]) begin
                write_reg(REG_GRID_ROWS, new_rows);
            end
            case ($urandom_range(0, 3))
                0:       pct = 0;
                1:       pct = 5;
                2:       pct = 20;
                default: pct = 50;
            endcase
            count = $urandom_range(1, 30);
            send_grid_run(count, pct);
            sent += count;
            wait_idle();
        end
    endtask

    // ------------------------------------------------------------------------
    // receiver: stall patterns that change every so often, plus a long hold-off
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (hold_request) begin
            hold_left    = LONG_HOLD;
            hold_request = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            if (rx_left == 0) begin
                rx_mode = rx_mode_t'($urandom_range(0, 3));
                rx_left = $urandom_range(16, 200);
            end
            rx_left--;
            rx_phase = ~rx_phase;
            case (rx_mode)
                RX_ALWAYS:    m_tready <= 1'b1;
                RX_ALTERNATE: m_tready <= rx_phase;
                RX_SPARSE:    m_tready <= ($urandom_range(0, 9) < 3);
                default:      m_tready <= ($urandom_range(0, 9) < 8);
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // result checker: every transfer against the oldest owed corner
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        result_t owed;
        if (aresetn && m_tvalid === 1'b1 && m_tready) begin
            if (expected_corners.size() == 0) begin
                failures++;
                reports++;
                if (reports <= MAX_REPORTS) begin
                    $display("unexpected corner x=%0d y=%0d family=%0d",
                             m_tdata[7:0], m_tdata[15:8], m_tuser[0]);
                end
            end else begin
                owed = expected_corners.pop_front();
                if (m_tdata[7:0] !== owed.center_x || m_tdata[15:8] !== owed.center_y ||
                    m_tuser[0] !== owed.pattern_family) begin
                    failures++;
                    reports++;
                    if (reports <= MAX_REPORTS) begin
                        $display("mismatch: exp x=%0d y=%0d fam=%0d, got x=%0d y=%0d fam=%0d",
                                 owed.center_x, owed.center_y, owed.pattern_family,
                                 m_tdata[7:0], m_tdata[15:8], m_tuser[0]);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin
        // shadow state as after reset
        upper_left    = 1'b0;
        lower_left    = 1'b0;
        col_idx       = 0;
        row_idx       = 0;
        grid_cols_reg = GRID_DIM_RESET;
        grid_rows_reg = GRID_DIM_RESET;
        failures      = 0;
        reports       = 0;
        cycle_count   = 0;
        burst_left    = 0;
        offering      = 1'b0;
        hold_request  = 1'b0;
        hold_left     = 0;
        rx_mode       = RX_ALWAYS;
        rx_left       = 0;
        rx_phase      = 1'b0;

        // synchronous reset, held from time zero
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_size();
        test_directed_windows();
        test_midgrid_writes();
        test_extreme_sizes();
        test_backpressure();
        test_drain_pause();
        test_random_grids();

        // final drain, then a wait to catch stray results
        wait_idle();
        repeat (20) @(posedge aclk);
        if (failures == 0) begin
            $display("status: pass");
        end else begin
            $display("%0d failures", failures);
            $display("status: fail");
        end
        $finish;
    end

endmodule
